/* rtl/core/snr_pkg.sv */
// Package for the segment number renderer: command codes, glyph and placement
// tables, and the per-byte mask type. No dependencies.
`timescale 1ns / 1ps
package snr_pkg;

  typedef enum logic [2:0] {
    CMD_BIG = 3'd0,
    CMD_SMALL = 3'd1,
    CMD_BATT = 3'd2,
    CMD_BLE = 3'd3,
    CMD_CONN = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RUN
  } state_t;

  localparam int MAP_BYTES = 32;
  typedef logic [MAP_BYTES-1:0][7:0] mask_t;

  localparam logic [3:0] GLYPH_L = 4'd10;
  localparam logic [3:0] GLYPH_O = 4'd11;
  localparam logic [3:0] GLYPH_H = 4'd12;
  localparam logic [3:0] GLYPH_I = 4'd13;
  localparam logic [3:0] GLYPH_NONE = 4'd15;

  // Segment set per glyph, bit s-1 for segment s.
  function automatic logic [12:0] glyph_segs(input logic [3:0] g);
    logic [12:0] r;
    case (g)
      4'd0: r = 13'h0FFF;
      4'd1: r = 13'h003E;
      4'd2: r = 13'h1BEF;
      4'd3: r = 13'h1AFF;
      4'd4: r = 13'h1E3E;
      4'd5: r = 13'h1EFB;
      4'd6: r = 13'h1FFB;
      4'd7: r = 13'h083F;
      4'd8: r = 13'h1FFF;
      4'd9: r = 13'h1EFF;
      4'd10: r = 13'h0FE2;
      4'd11: r = 13'h13F8;
      4'd12: r = 13'h1FBE;
      4'd13: r = 13'h0300;
      default: r = 13'h0000;
    endcase
    return r;
  endfunction

  // Byte (high 5 bits) and bit (low 3 bits) of segment s at a digit place.
  // Each row lists the last segment first.
  function automatic logic [7:0] place_map(input logic [2:0] p, input logic [3:0] s);
    logic [103:0] row;
    case (p)
      3'd0: row = {8'h4B, 8'h68, 8'h77, 8'h76, 8'h75, 8'h74, 8'h4A, 8'h39,
                   8'h38, 8'h47, 8'h46, 8'h45, 8'h4C};
      3'd1: row = {8'h25, 8'h32, 8'h34, 8'h35, 8'h36, 8'h28, 8'h2C, 8'h27,
                   8'h26, 8'h21, 8'h20, 8'h2F, 8'h33};
      3'd2: row = {8'h15, 8'h09, 8'h17, 8'h14, 8'h12, 8'h1F, 8'h10, 8'h11,
                   8'h13, 8'h16, 8'h08, 8'h0F, 8'h0E};
      3'd3: row = {8'h7F, 8'h73, 8'h71, 8'h7E, 8'h87, 8'h84, 8'h85, 8'h86,
                   8'h78, 8'h70, 8'h72, 8'h6A, 8'h69};
      3'd4: row = {8'h4F, 8'h57, 8'h48, 8'h4D, 8'h56, 8'h54, 8'h55, 8'h3B,
                   8'h44, 8'h41, 8'h42, 8'h43, 8'h4E};
      3'd5: row = {8'h19, 8'h30, 8'h3E, 8'h18, 8'h1B, 8'h1D, 8'h00, 8'h01,
                   8'h1C, 8'h1A, 8'h3F, 8'h2A, 8'h29};
      default: row = '0;
    endcase
    return row[s * 8 +: 8];
  endfunction

  // OR a glyph at a place into the set mask.
  function automatic mask_t draw(input mask_t m, input logic [3:0] g, input logic [2:0] p);
    mask_t r;
    logic [12:0] segs;
    logic [7:0] bb;
    r = m;
    segs = glyph_segs(g);
    for (int s = 0; s < 13; s++) begin
      bb = place_map(p, 4'(s));
      if (segs[s] && p <= 3'd5) r[bb[7:3]][bb[2:0]] = 1'b1;
    end
    return r;
  endfunction

endpackage

/* rtl/core/segment_number_renderer_top.sv */
// Top level of the segment number renderer: buffer memory, digit split and dump.
// Depends on snr_pkg and snr_render.
// One read-modify-write is in flight at a time: each byte is read, modified, written
// back and presented before the next read starts, and output stalls hold it.
// Reset: a clearing pass zeroes the whole buffer; no command is taken meanwhile.
// scale resets to 1.
`timescale 1ns / 1ps
module segment_number_renderer_top #(
  parameter int BUF_BYTES = 18
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic signed [15:0] number,
  input  logic [7:0]  symbol,
  input  logic        flag,
  input  logic [7:0]  level,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  byte_index,
  output logic [7:0]  byte_value,
  output logic        last
);

  localparam int AW = $clog2(BUF_BYTES);

  snr_pkg::state_t state, state_next;
  logic [7:0] mem [BUF_BYTES];
  logic scale;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [AW:0] rd_cnt;
  logic rd_pend, wr_en;
  logic [7:0] rd_data, wr_data;
  logic [2:0] c_cmd;
  logic c_flag;
  logic [7:0] c_sym, c_lvl;
  logic c_hi, c_lo, c_pt, c_neg, c_one;
  logic [10:0] c_m;
  logic [3:0] c_h, c_t, c_u;
  snr_pkg::mask_t clr_m, set_m;

  // Number preprocessing on input: range checks, rounding and magnitude.
  logic signed [16:0] v17, vr;
  logic is_big, hi, lo, pt, ng;
  logic [14:0] mag, q;
  logic [10:0] m, h1, t1;
  logic [3:0] gh, gt, gu;
  always_comb begin
    is_big = (cmd == snr_pkg::CMD_BIG);
    v17 = 17'(number);
    hi = is_big ? (v17 > 17'sd19995) : (v17 > 17'sd9995);
    lo = v17 < -17'sd995;
    pt = !((is_big ? (v17 > 17'sd1999) : (v17 > 17'sd999)) || v17 < -17'sd99);
    vr = v17 + 17'sd5;
    mag = vr[16] ? 15'(-vr) : vr[14:0];
    q = 15'((32'(mag) * 32'd6554) >> 16);
    if (15'(q * 15'd10) > mag) q = q - 15'd1;
    if (pt) begin
      ng = v17[16];
      m = v17[16] ? 11'(-v17) : v17[10:0];
    end else begin
      ng = vr[16] && q != 15'd0;
      m = q[10:0];
    end
  end

  // Digit split of the registered magnitude, registered again before use.
  always_comb begin
    h1 = 11'((22'(c_m) * 22'd1311) >> 17);
    t1 = 11'((24'(c_m) * 24'd6554) >> 16);
    gu = 4'(c_m - 11'(t1 * 11'd10));
    gt = 4'(t1 - 11'(((22'(t1) * 22'd6554) >> 16) * 11'd10));
    gh = 4'(h1 - 11'(((22'(h1) * 22'd6554) >> 16) * 11'd10));
    if (c_m <= 11'd99) gh = snr_pkg::GLYPH_NONE;
    if (c_m <= 11'd9) gt = 4'd0;
  end

  snr_render u_render (
    .cmd(c_cmd), .flag(c_flag), .symbol(c_sym), .level(c_lvl), .scale(scale),
    .is_hi(c_hi), .is_lo(c_lo), .point(c_pt), .neg(c_neg), .one(c_one),
    .g_hund(c_h), .g_tens(c_t), .g_unit(c_u), .clr(clr_m), .set(set_m)
  );

  assign in_ready = (state == snr_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // Control.
  always_comb begin
    state_next = state;
    case (state)
      snr_pkg::ST_CLEAR: if (wr_addr == AW'(BUF_BYTES - 1)) state_next = snr_pkg::ST_IDLE;
      snr_pkg::ST_IDLE: if (in_valid) state_next = snr_pkg::ST_RUN;
      snr_pkg::ST_RUN: if (last && out_valid && out_ready) state_next = snr_pkg::ST_IDLE;
      default: state_next = snr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= snr_pkg::ST_CLEAR;
      scale <= 1'b1;
      rd_cnt <= '0;
      rd_pend <= 1'b0;
      wr_en <= 1'b0;
      wr_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) scale <= cfg_data;
      wr_en <= 1'b0;
      rd_pend <= 1'b0;
      if (state == snr_pkg::ST_CLEAR) wr_addr <= wr_addr + AW'(1);
      if (in_valid && in_ready) begin
        c_cmd <= cmd; c_flag <= flag; c_sym <= symbol; c_lvl <= level;
        c_hi <= hi; c_lo <= lo; c_pt <= pt; c_neg <= ng;
        c_one <= is_big && m > 11'd999;
        c_m <= m;
        rd_cnt <= '0;
      end
      // Digits are registered in the cycle after accept, before the first write back needs them.
      c_h <= gh; c_t <= gt; c_u <= gu;
      if (out_valid && out_ready) out_valid <= 1'b0;
      // One byte in flight: read, modify, write and present.
      if (state == snr_pkg::ST_RUN && !rd_pend && !wr_en && !out_valid &&
          rd_cnt < (AW+1)'(BUF_BYTES)) begin
        rd_addr <= rd_cnt[AW-1:0];
        rd_pend <= 1'b1;
        rd_cnt <= rd_cnt + (AW+1)'(1);
      end
      if (rd_pend) begin
        wr_en <= 1'b1;
        wr_addr <= rd_addr;
        wr_data <= (rd_data & ~clr_m[5'(rd_addr)]) | set_m[5'(rd_addr)];
      end
      if (wr_en && state == snr_pkg::ST_RUN) begin
        out_valid <= 1'b1;
        byte_index <= 5'(wr_addr);
        byte_value <= wr_data;
        last <= wr_addr == AW'(BUF_BYTES - 1);
      end
    end
  end

  // Buffer memory.
  always_ff @(posedge clk) begin
    if (state == snr_pkg::ST_CLEAR) mem[wr_addr] <= 8'h00;
    else if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_cnt[AW-1:0]];
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state == snr_pkg::ST_RUN |-> !in_ready) else $error("accept while busy");
  a_out_in_run: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == snr_pkg::ST_RUN) else $error("output outside run");
  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    rd_pend |=> wr_en) else $error("lost write back");

endmodule

/* rtl/core/snr_render.sv */
// Command decoder: turns one registered command into per-byte clear and set masks.
// Depends on snr_pkg. Digit values arrive already split by the top level.
`timescale 1ns / 1ps
module snr_render (
  input  logic [2:0]  cmd,
  input  logic        flag,
  input  logic [7:0]  symbol,
  input  logic [7:0]  level,
  input  logic        scale,
  input  logic        is_hi,
  input  logic        is_lo,
  input  logic        point,
  input  logic        neg,
  input  logic        one,
  input  logic [3:0]  g_hund,
  input  logic [3:0]  g_tens,
  input  logic [3:0]  g_unit,
  output snr_pkg::mask_t clr,
  output snr_pkg::mask_t set
);

  logic [2:0] base;
  logic [7:0] t0, t1, t2, t3, t4;

  // Bar thresholds by scale.
  always_comb begin
    if (scale) begin
      t0 = 8'd32; t1 = 8'd66; t2 = 8'd98; t3 = 8'd134; t4 = 8'd166;
    end else begin
      t0 = 8'd16; t1 = 8'd33; t2 = 8'd49; t3 = 8'd67; t4 = 8'd83;
    end
  end

  // Mask build per command.
  always_comb begin
    clr = '0;
    set = '0;
    base = (cmd == snr_pkg::CMD_SMALL) ? 3'd3 : 3'd0;
    case (cmd)
      snr_pkg::CMD_BIG, snr_pkg::CMD_SMALL: begin
        if (cmd == snr_pkg::CMD_BIG) begin
          clr[1] = 8'hFF; clr[2] = 8'hFF; clr[3] = 8'hC0; clr[4] = 8'hFF;
          clr[5] = 8'h91; clr[6] = 8'h7C; clr[7] = 8'h03; clr[8] = 8'hE0;
          clr[9] = 8'h1C; clr[13] = 8'h01; clr[14] = 8'hF0; clr[15] = 8'h3E;
          if (symbol[5]) set[1] = set[1] | 8'h0C;
          if (symbol[6]) set[1] = set[1] | 8'h10;
          if (symbol[7]) set[1] = set[1] | 8'h20;
        end else begin
          clr[0] = 8'h07; clr[3] = 8'h3F; clr[5] = 8'h0E; clr[6] = 8'h01;
          clr[7] = 8'hC8; clr[8] = 8'h1E; clr[9] = 8'hE1; clr[10] = 8'hF0;
          clr[13] = 8'h06; clr[14] = 8'h0F; clr[15] = 8'hC1; clr[16] = 8'hF0;
          if (flag) set[5] = set[5] | 8'h08;
        end
        if (is_hi) begin
          set = snr_pkg::draw(set, snr_pkg::GLYPH_H, base);
          set = snr_pkg::draw(set, snr_pkg::GLYPH_I, base + 3'd1);
        end else if (is_lo) begin
          set = snr_pkg::draw(set, snr_pkg::GLYPH_L, base);
          set = snr_pkg::draw(set, snr_pkg::GLYPH_O, base + 3'd1);
        end else begin
          if (point) begin
            if (cmd == snr_pkg::CMD_BIG) set[3] = set[3] | 8'h40;
            else set[0] = set[0] | 8'h04;
          end
          if (neg) begin
            if (cmd == snr_pkg::CMD_BIG) set[9] = set[9] | 8'h08;
            else set[15] = set[15] | 8'h80;
          end
          if (one) set[15] = set[15] | 8'h3E;
          set = snr_pkg::draw(set, g_hund, base);
          set = snr_pkg::draw(set, g_tens, base + 3'd1);
          set = snr_pkg::draw(set, g_unit, base + 3'd2);
        end
      end
      snr_pkg::CMD_BATT: begin
        clr[5] = 8'h60; clr[6] = 8'h82; clr[7] = 8'h30;
        if (flag) begin
          set[7][4] = 1'b1;
          set[5][6] = level >= t0;
          set[5][5] = level >= t1;
          set[6][7] = level >= t2;
          set[6][1] = level >= t3;
          set[7][5] = level >= t4;
        end
      end
      snr_pkg::CMD_BLE: begin
        clr[9] = 8'h02;
        if (flag) set[9] = 8'h02;
      end
      snr_pkg::CMD_CONN: begin
        clr[7] = 8'h04;
        if (flag) set[7] = 8'h04;
      end
      default: ;
    endcase
  end

endmodule
